FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_NR(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

FILE: rtl/core/imtap_pkg.sv
// ----------------------------------------------------------------------------
// imtap_pkg
// shared widths, defaults and state types of the frame maximum unit
// ----------------------------------------------------------------------------
package imtap_pkg;

  // fixed field widths on the ports
  localparam int VAL_W     = 33;
  localparam int COORD_IN_W = 16;
  localparam int AVG_OUT_W = 24;
  localparam int CNT_OUT_W = 32;

  // packed stream widths (whole bytes)
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 120;

  // parameter defaults
  localparam int DEF_COORD_BITS  = 16;
  localparam int DEF_COUNT_BITS  = 32;
  localparam int DEF_FRAC_BITS   = 8;
  localparam int DEF_QUEUE_DEPTH = 2;

  // back end divider sequencer
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

endpackage

FILE: rtl/core/imtap_front.sv
// ----------------------------------------------------------------------------
// imtap_front
// per-sample running maximum with tie position sums and count
// ----------------------------------------------------------------------------
module imtap_front
  import imtap_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int SUM_W = COORD_BITS + COUNT_BITS,
  localparam int REC_W = VAL_W + 2 * SUM_W + COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VAL_W-1:0]        sample,
  input  logic [COORD_IN_W-1:0]   column,
  input  logic [COORD_IN_W-1:0]   row,
  input  logic                    last,
  output logic                    rec_valid,
  input  logic                    rec_ready,
  output logic [REC_W-1:0]        rec_data   // best, column sum, row sum, count
);

  logic [VAL_W-1:0]      best_value, best_value_next;
  logic [SUM_W-1:0]      column_sum, column_sum_next;
  logic [SUM_W-1:0]      row_sum, row_sum_next;
  logic [COUNT_BITS-1:0] hit_count, hit_count_next;

  logic                  accept;
  logic                  is_first;
  logic                  is_greater;
  logic                  is_equal;
  logic                  is_sat;
  logic [SUM_W-1:0]      col_ext;
  logic [SUM_W-1:0]      row_ext;

  // a frame can close only when the queue has room for its record
  assign in_ready  = rec_ready;
  assign accept    = in_valid && in_ready;
  assign rec_valid = accept && last;

  // coordinates masked to the configured width
  assign col_ext = SUM_W'(COORD_BITS'(column));
  assign row_ext = SUM_W'(COORD_BITS'(row));

  // classify the sample against the running maximum
  assign is_first   = (hit_count == '0);
  assign is_greater = $signed(sample) > $signed(best_value);
  assign is_equal   = (sample == best_value);
  assign is_sat     = &hit_count;

  // fold the sample into the running state
  always_comb begin
    best_value_next = best_value;
    column_sum_next = column_sum;
    row_sum_next    = row_sum;
    hit_count_next  = hit_count;
    if (is_first || is_greater) begin
      best_value_next = sample;
      column_sum_next = col_ext;
      row_sum_next    = row_ext;
      hit_count_next  = COUNT_BITS'(1);
    end else if (is_equal && !is_sat) begin
      column_sum_next = column_sum + col_ext;
      row_sum_next    = row_sum + row_ext;
      hit_count_next  = hit_count + COUNT_BITS'(1);
    end
  end

  // record of the closed frame
  assign rec_data = {hit_count_next, row_sum_next, column_sum_next, best_value_next};

  // state update, cleared after the last beat of a frame
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      best_value <= '0;
      column_sum <= '0;
      row_sum    <= '0;
      hit_count  <= '0;
    end else if (accept) begin
      best_value <= best_value_next;
      column_sum <= column_sum_next;
      row_sum    <= row_sum_next;
      hit_count  <= hit_count_next;
    end
  end

endmodule

FILE: rtl/core/imtap_queue.sv
// ----------------------------------------------------------------------------
// imtap_queue
// short register queue of closed frame records
// ----------------------------------------------------------------------------
module imtap_queue
  import imtap_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = DEF_QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != (PW+1)'(DEPTH));
  assign out_valid = (fill != '0);
  assign out_data  = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PW+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/core/imtap_divider.sv
// ----------------------------------------------------------------------------
// imtap_divider
// bit-serial mean of the tie positions and the result register
// ----------------------------------------------------------------------------
module imtap_divider
  import imtap_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  localparam int SUM_W = COORD_BITS + COUNT_BITS,
  localparam int REC_W = VAL_W + 2 * SUM_W + COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REC_W-1:0]      in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VAL_W-1:0]      max_value,
  output logic [AVG_OUT_W-1:0]  avg_column,
  output logic [AVG_OUT_W-1:0]  avg_row,
  output logic [CNT_OUT_W-1:0]  tie_count
);

  localparam int DW     = SUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DW + 1);
  localparam int AVG_W  = (COORD_BITS + FRAC_BITS > AVG_OUT_W) ? AVG_OUT_W
                                                                : COORD_BITS + FRAC_BITS;
  localparam logic [AVG_OUT_W-1:0] AVG_MASK = AVG_OUT_W'((64'd1 << AVG_W) - 64'd1);

  div_state_t state, state_next;

  logic [STEP_W-1:0]     step;
  logic [VAL_W-1:0]      best;
  logic [COUNT_BITS-1:0] divisor;
  logic [DW-1:0]         c_dvd, r_dvd;
  logic [COUNT_BITS-1:0] c_rem, r_rem;
  logic [AVG_OUT_W-1:0]  c_quo, r_quo;

  logic [VAL_W-1:0]      rec_best;
  logic [SUM_W-1:0]      rec_csum;
  logic [SUM_W-1:0]      rec_rsum;
  logic [COUNT_BITS-1:0] rec_cnt;

  logic [COUNT_BITS:0]   c_trial, r_trial;
  logic                  c_ge, r_ge;
  logic [COUNT_BITS-1:0] c_rem_next, r_rem_next;
  logic                  take;
  logic                  load_out;

  // record fields
  assign {rec_cnt, rec_rsum, rec_csum, rec_best} = in_data;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (in_valid) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (step == STEP_W'(1)) begin
          state_next = DIV_HOLD;
        end
      end
      DIV_HOLD: begin
        if (load_out) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      DIV_IDLE: in_ready = 1'b1;
      DIV_RUN:  in_ready = 1'b0;
      DIV_HOLD: load_out = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one restoring step for each coordinate
  always_comb begin
    c_trial    = {c_rem, c_dvd[DW-1]};
    r_trial    = {r_rem, r_dvd[DW-1]};
    c_ge       = (c_trial >= {1'b0, divisor});
    r_ge       = (r_trial >= {1'b0, divisor});
    c_rem_next = c_ge ? COUNT_BITS'(c_trial - {1'b0, divisor}) : COUNT_BITS'(c_trial);
    r_rem_next = r_ge ? COUNT_BITS'(r_trial - {1'b0, divisor}) : COUNT_BITS'(r_trial);
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (take) begin
      best    <= rec_best;
      divisor <= rec_cnt;
      c_dvd   <= DW'(rec_csum) << FRAC_BITS;
      r_dvd   <= DW'(rec_rsum) << FRAC_BITS;
      c_rem   <= '0;
      r_rem   <= '0;
      c_quo   <= '0;
      r_quo   <= '0;
      step    <= STEP_W'(DW);
    end else if (state == DIV_RUN) begin
      c_dvd   <= c_dvd << 1;
      r_dvd   <= r_dvd << 1;
      c_rem   <= c_rem_next;
      r_rem   <= r_rem_next;
      c_quo   <= {c_quo[AVG_OUT_W-2:0], c_ge};
      r_quo   <= {r_quo[AVG_OUT_W-2:0], r_ge};
      step    <= step - STEP_W'(1);
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      max_value  <= best;
      avg_column <= c_quo & AVG_MASK;
      avg_row    <= r_quo & AVG_MASK;
      tie_count  <= CNT_OUT_W'(divisor);
    end
  end

endmodule

FILE: rtl/core/image_max_tie_avg_position_unit.sv
// ----------------------------------------------------------------------------
// image_max_tie_avg_position_unit
// frame maximum with the mean column and row of the samples that reach it
// ----------------------------------------------------------------------------
// throughput: one sample beat per cycle while the queue has room; the back end
//   divides one frame at a time and takes the next record only once the last
//   result is loaded, and the input stalls while QUEUE_DEPTH closed frames wait
// order: the last beat of a frame pushes its record into the queue; the idle back
//   end takes it, runs the restoring division and then loads the result register
// reset: rst clears the running maximum, the queue and the result register
module image_max_tie_avg_position_unit
  import imtap_pkg::*;
#(
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // sample_value, column, row, zero pad
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // max_value, avg_column, avg_row,
                                         // tie_count, zero pad
);

  localparam int SUM_W = COORD_BITS + COUNT_BITS;
  localparam int REC_W = VAL_W + 2 * SUM_W + COUNT_BITS;

  logic [VAL_W-1:0]      sample;
  logic [COORD_IN_W-1:0] column;
  logic [COORD_IN_W-1:0] row;

  logic                  push_valid, push_ready;
  logic [REC_W-1:0]      push_data;
  logic                  pop_valid, pop_ready;
  logic [REC_W-1:0]      pop_data;

  logic [VAL_W-1:0]      max_value;
  logic [AVG_OUT_W-1:0]  avg_column;
  logic [AVG_OUT_W-1:0]  avg_row;
  logic [CNT_OUT_W-1:0]  tie_count;

  // unpack the input beat
  assign sample = s_tdata[VAL_W-1:0];
  assign column = s_tdata[VAL_W+COORD_IN_W-1:VAL_W];
  assign row    = s_tdata[VAL_W+2*COORD_IN_W-1:VAL_W+COORD_IN_W];

  // front: accumulate per sample
  imtap_front #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .sample    (sample),
    .column    (column),
    .row       (row),
    .last      (s_tlast),
    .rec_valid (push_valid),
    .rec_ready (push_ready),
    .rec_data  (push_data)
  );

  // queue of closed frames
  imtap_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  // back: divide and hold the result
  imtap_divider #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pop_valid),
    .in_ready   (pop_ready),
    .in_data    (pop_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .max_value  (max_value),
    .avg_column (avg_column),
    .avg_row    (avg_row),
    .tie_count  (tie_count)
  );

  // pack the result beat
  assign m_tdata = {
    (M_DATA_W - VAL_W - 2 * AVG_OUT_W - CNT_OUT_W)'(0),
    tie_count, avg_row, avg_column, max_value
  };

endmodule

FILE: rtl/core/imtap_checker.sv
// ----------------------------------------------------------------------------
// imtap_checker
// port-level checks of the frame maximum unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imtap_checker
  import imtap_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  localparam int TIE_LO = VAL_W + 2 * AVG_OUT_W;

  // a stalled result beat stays offered
  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")

  // a stalled result beat keeps its data
  `ASSERT_CLK(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")

  // every result covers at least one maximum sample
  `ASSERT_CLK(a_tie_nonzero, clk, rst, m_tvalid |-> (m_tdata[TIE_LO+CNT_OUT_W-1:TIE_LO] != '0), "zero tie count")

  // reset empties the result register
  `ASSERT_CLK_NR(a_reset_empty, clk, rst |=> !m_tvalid, "result offered right after reset")

endmodule

bind image_max_tie_avg_position_unit imtap_checker u_imtap_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
